// ===== design/md5_stream_hash_top_defines.svh =====
// assertion macros for the md5 stream hash block
`ifndef MD5_STREAM_HASH_TOP_DEFINES_SVH
`define MD5_STREAM_HASH_TOP_DEFINES_SVH

// antecedent holds, consequent must hold on the next clock
`define MD5_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("md5 check failed");

// antecedent holds, consequent must hold in the same clock
`define MD5_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("md5 check failed");

`endif

// ===== design/md5_pkg.sv =====
package md5_pkg;

	localparam logic [31:0] H_INIT0 = 32'h67452301;
	localparam logic [31:0] H_INIT1 = 32'hefcdab89;
	localparam logic [31:0] H_INIT2 = 32'h98badcfe;
	localparam logic [31:0] H_INIT3 = 32'h10325476;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam logic [1:0] MODE_DATA = 2'd0;
	localparam logic [1:0] MODE_PAD = 2'd1;
	localparam logic [1:0] MODE_LEN = 2'd2;

	typedef struct packed {
		logic acc_byte;
		logic start;
		logic round;
		logic fin;
		logic emit;
		logic [1:0] mode;
		logic [5:0] rnd;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic out_busy;
	} status_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [3:0] sel);
		logic [4:0] s;
		case (sel)
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index used by a round
	function automatic logic [3:0] msg_idx(input logic [5:0] i);
		logic [3:0] i4;
		logic [3:0] k;
		i4 = i[3:0];
		case (i[5:4])
			2'd0: k = i4;
			2'd1: k = i4 * 4'd5 + 4'd1;
			2'd2: k = i4 * 4'd3 + 4'd5;
			default: k = i4 * 4'd7;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage

// ===== design/md5_stream_hash_top.sv =====
// MD5 over a byte stream. One word (an optional byte plus an end flag) is taken per cycle
// while the 64-byte block fills; the word that completes a block, or that ends the message,
// starts a compression (load, 64 rounds at one round per cycle, chaining add)
// during which in_ready is low. Message end adds one padding block, or two when 56 or more
// bytes sit in the last block, so the digest follows one or two compressions after the ending
// word (plus one block when that word also fills a block). A long message's rate is thus set
// by the single round unit, since no byte is taken while it runs. The digest comes out as two
// 64-bit words, bytes 0..7 first with last_half low, then bytes 8..15 with last_half high; it
// sits in its own register, so the next message may start while it waits to be taken.
module md5_stream_hash_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic has_byte,
	input  logic [7:0] message_byte,
	input  logic end_of_message,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] digest_half,
	output logic last_half
);

	md5_pkg::cmd_t cmd;
	md5_pkg::status_t st;

	md5_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_byte(has_byte),
		.end_of_message(end_of_message),
		.st(st),
		.cmd(cmd)
	);

	md5_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.message_byte(message_byte),
		.cmd(cmd),
		.st(st),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_half(digest_half),
		.last_half(last_half)
	);

endmodule

// ===== design/md5_ctrl.sv =====
module md5_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic has_byte,
	input  logic end_of_message,
	input  md5_pkg::status_t st,
	output md5_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_ROUND = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic eom_q, eom_d;
	logic [5:0] rnd_q, rnd_d;
	logic last_blk;

	assign last_blk = (mode_q == md5_pkg::MODE_LEN)
		|| ((mode_q == md5_pkg::MODE_PAD) && (st.fill < md5_pkg::LEN_POS));

	always_comb begin
		cmd = '0;
		cmd.mode = mode_q;
		cmd.rnd = rnd_q;
		in_ready = (state_q == S_IDLE);
		state_d = state_q;
		mode_d = mode_q;
		eom_d = eom_q;
		rnd_d = rnd_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.acc_byte = has_byte;
					if (has_byte && (st.fill == md5_pkg::FILL_LAST)) begin
						mode_d = md5_pkg::MODE_DATA;
						eom_d = end_of_message;
						state_d = S_START;
					end else if (end_of_message) begin
						mode_d = md5_pkg::MODE_PAD;
						eom_d = 1'b0;
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				rnd_d = '0;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				rnd_d = rnd_q + 6'd1;
				if (rnd_q == md5_pkg::FILL_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (last_blk) begin
					// digest waits until the output register is free
					if (!st.out_busy) begin
						cmd.fin = 1'b1;
						cmd.emit = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.fin = 1'b1;
					if ((mode_q == md5_pkg::MODE_DATA) && eom_q) begin
						mode_d = md5_pkg::MODE_PAD;
						eom_d = 1'b0;
						state_d = S_START;
					end else if (mode_q == md5_pkg::MODE_PAD) begin
						mode_d = md5_pkg::MODE_LEN;
						state_d = S_START;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= md5_pkg::MODE_DATA;
			eom_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			eom_q <= eom_d;
			rnd_q <= rnd_d;
		end
	end

endmodule

// ===== design/md5_dp.sv =====
module md5_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] message_byte,
	input  md5_pkg::cmd_t cmd,
	output md5_pkg::status_t st,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] digest_half,
	output logic last_half
);

	logic [31:0] buf_q [16];
	logic [63:0] len_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] kw_q;
	logic [63:0] lo_q, hi_q;
	logic busy_q, half_q;

	logic [5:0] fill;
	logic [5:0] kw_idx;
	logic [3:0] widx;
	logic [31:0] raw_w, msg_w;
	logic [31:0] f, sum, b_new;
	logic [31:0] h_sum [4];

	assign fill = len_q[8:3];
	assign st.fill = fill;
	assign st.out_busy = busy_q;

	assign kw_idx = cmd.start ? 6'd0 : cmd.rnd + 6'd1;
	assign widx = md5_pkg::msg_idx(kw_idx);
	assign raw_w = buf_q[widx];

	// padding bytes are formed on the fly from fill and length
	always_comb begin
		logic [5:0] p;
		logic [7:0] bv;
		msg_w = '0;
		for (int j = 0; j < 4; j++) begin
			p = {widx, 2'(j)};
			if ((cmd.mode == md5_pkg::MODE_DATA)
				|| ((cmd.mode == md5_pkg::MODE_PAD) && (p < fill))) begin
				bv = raw_w[8*j +: 8];
			end else if ((cmd.mode == md5_pkg::MODE_PAD) && (p == fill)) begin
				bv = md5_pkg::PAD_MARK;
			end else if ((p >= md5_pkg::LEN_POS)
				&& ((cmd.mode == md5_pkg::MODE_LEN) || (fill < md5_pkg::LEN_POS))) begin
				bv = len_q[{p[2:0], 3'b000} +: 8];
			end else begin
				bv = 8'h00;
			end
			msg_w[8*j +: 8] = bv;
		end
	end

	always_comb begin
		case (cmd.rnd[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + kw_q;
		b_new = b_q + md5_pkg::rotl32(sum, md5_pkg::rot_amt({cmd.rnd[5:4], cmd.rnd[1:0]}));
	end

	assign h_sum[0] = h_q[0] + a_q;
	assign h_sum[1] = h_q[1] + b_q;
	assign h_sum[2] = h_q[2] + c_q;
	assign h_sum[3] = h_q[3] + d_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_byte) begin
			buf_q[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= message_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.round) begin
			kw_q <= md5_pkg::round_k(kw_idx) + msg_w;
		end
		if (cmd.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
		end else if (cmd.round) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (cmd.emit) begin
			lo_q <= {h_sum[1], h_sum[0]};
			hi_q <= {h_sum[3], h_sum[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			h_q[0] <= md5_pkg::H_INIT0;
			h_q[1] <= md5_pkg::H_INIT1;
			h_q[2] <= md5_pkg::H_INIT2;
			h_q[3] <= md5_pkg::H_INIT3;
		end else begin
			if (cmd.emit) begin
				len_q <= '0;
				h_q[0] <= md5_pkg::H_INIT0;
				h_q[1] <= md5_pkg::H_INIT1;
				h_q[2] <= md5_pkg::H_INIT2;
				h_q[3] <= md5_pkg::H_INIT3;
			end else begin
				if (cmd.acc_byte) begin
					len_q <= len_q + 64'd8;
				end
				if (cmd.fin) begin
					for (int n = 0; n < 4; n++) begin
						h_q[n] <= h_sum[n];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			half_q <= 1'b0;
		end else if (cmd.emit) begin
			busy_q <= 1'b1;
			half_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			if (half_q) begin
				busy_q <= 1'b0;
				half_q <= 1'b0;
			end else begin
				half_q <= 1'b1;
			end
		end
	end

	assign out_valid = busy_q;
	assign last_half = half_q;
	assign digest_half = half_q ? hi_q : lo_q;

endmodule

// ===== design/md5_checker.sv =====
`include "md5_stream_hash_top_defines.svh"

module md5_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic has_byte,
	input logic end_of_message,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] digest_half,
	input logic last_half
);

	// stalled output word holds
	`MD5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digest_half) && $stable(last_half))

	// first half taken, second half follows at once
	`MD5_ASSERT_NEXT(a_second_half, out_valid && out_ready && !last_half, out_valid && last_half)

	// nothing new can follow the final half in the next cycle
	`MD5_ASSERT_NEXT(a_gap_after_digest, out_valid && out_ready && last_half, !out_valid)

	// an empty word does not start any work
	`MD5_ASSERT_NEXT(a_empty_word, in_valid && in_ready && !has_byte && !end_of_message, in_ready)

	`MD5_ASSERT_SAME(a_last_only_valid, last_half, out_valid)

endmodule

bind md5_stream_hash_top md5_checker u_md5_checker (.*);

// ===== tb/sv/md5_stream_hash_top_tb.sv =====
`timescale 1ns / 100ps

module md5_stream_hash_top_tb;

	localparam int ITEM_TARGET = 1850;
	localparam int PHASE_COUNT = 4;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic has_byte;
		logic [7:0] message_byte;
		logic end_of_message;
	} stream_word_t;

	typedef struct packed {
		logic [63:0] digest_half;
		logic last_half;
	} digest_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic has_byte = 1'b0;
	logic [7:0] message_byte = 8'h00;
	logic end_of_message = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] digest_half;
	logic last_half;

	md5_stream_hash_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_byte(has_byte),
		.message_byte(message_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_half(digest_half),
		.last_half(last_half)
	);

	stream_word_t word_q[$];
	digest_word_t digest_q[$];
	stream_word_t drive_word;
	digest_word_t got_word;
	digest_word_t want_word;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	logic word_accepted = 1'b0;

	int item_count = 0;
	int message_count = 0;
	int byte_count = 0;
	int result_count = 0;
	int err_count = 0;
	int idle_cycles = 0;

	logic [31:0] md5_sine[64];
	int md5_shift[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
	logic [31:0] md5_chain[4];
	logic [7:0] md5_block[64];
	logic [63:0] md5_bits;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic md5_restart();
		md5_chain[0] = 32'h67452301;
		md5_chain[1] = 32'hefcdab89;
		md5_chain[2] = 32'h98badcfe;
		md5_chain[3] = 32'h10325476;
		md5_bits = 64'd0;
	endtask

	task automatic md5_compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, f, t, sum;
		int i, g, k, s;
		for (i = 0; i < 16; i++)
			w[i] = {md5_block[4 * i + 3], md5_block[4 * i + 2],
				md5_block[4 * i + 1], md5_block[4 * i]};
		a = md5_chain[0];
		b = md5_chain[1];
		c = md5_chain[2];
		d = md5_chain[3];
		for (i = 0; i < 64; i++) begin
			g = i / 16;
			case (g)
				0: begin
					f = (b & c) | (~b & d);
					k = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					k = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					k = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					k = (7 * i) % 16;
				end
			endcase
			sum = a + f + md5_sine[i] + w[k];
			s = md5_shift[g * 4 + i % 4];
			t = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
			a = t;
		end
		md5_chain[0] += a;
		md5_chain[1] += b;
		md5_chain[2] += c;
		md5_chain[3] += d;
	endtask

	task automatic md5_take_word(input logic has, input logic [7:0] data, input logic eom);
		int pos;
		digest_word_t dw;
		if (has) begin
			pos = md5_bits[8:3];
			md5_block[pos] = data;
			md5_bits += 64'd8;
			if (pos == 63)
				md5_compress();
		end
		if (eom) begin
			pos = md5_bits[8:3];
			md5_block[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					md5_block[pos] = 8'h00;
					pos++;
				end
				md5_compress();
				pos = 0;
			end
			while (pos < 56) begin
				md5_block[pos] = 8'h00;
				pos++;
			end
			for (pos = 0; pos < 8; pos++)
				md5_block[56 + pos] = md5_bits[8 * pos +: 8];
			md5_compress();
			dw.digest_half = {md5_chain[1], md5_chain[0]};
			dw.last_half = 1'b0;
			digest_q.push_back(dw);
			dw.digest_half = {md5_chain[3], md5_chain[2]};
			dw.last_half = 1'b1;
			digest_q.push_back(dw);
			md5_restart();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_count++;
		$display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
	endtask

	task automatic push_word(input logic has, input logic [7:0] data, input logic eom);
		stream_word_t sw;
		sw.has_byte = has;
		sw.message_byte = data;
		sw.end_of_message = eom;
		word_q.push_back(sw);
		item_count++;
	endtask

	task automatic push_message(input int len);
		int j;
		logic eom_on_byte;
		eom_on_byte = (len > 0) && ($urandom_range(1) == 1);
		for (j = 0; j < len; j++) begin
			// ignored word between message bytes
			if ($urandom_range(9) == 0)
				push_word(1'b0, 8'($urandom), 1'b0);
			push_word(1'b1, 8'($urandom), eom_on_byte && (j == len - 1));
		end
		if (!eom_on_byte)
			push_word(1'b0, 8'($urandom), 1'b1);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_accepted) begin
			if (word_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				drive_word = word_q.pop_front();
				in_valid <= 1'b1;
				has_byte <= drive_word.has_byte;
				message_byte <= drive_word.message_byte;
				end_of_message <= drive_word.end_of_message;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_req) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			word_accepted <= 1'b0;
		end else begin
			word_accepted <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				got_word.digest_half = digest_half;
				got_word.last_half = last_half;
				result_count++;
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", got_word.digest_half, 64'd0);
				end else begin
					want_word = digest_q.pop_front();
					if (got_word.digest_half !== want_word.digest_half)
						report_mismatch("digest_half", got_word.digest_half,
							want_word.digest_half);
					if (got_word.last_half !== want_word.last_half)
						report_mismatch("last_half", 64'(got_word.last_half),
							64'(want_word.last_half));
				end
			end
			if (in_valid && in_ready) begin
				if (has_byte)
					byte_count++;
				if (end_of_message)
					message_count++;
				md5_take_word(has_byte, message_byte, end_of_message);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("md5_stream_hash_top test failed");
				$finish;
			end
		end
	end

	initial begin
		int i, ph, r, len, phase_end;
		real sine_mag;
		logic [63:0] sine_bits;
		for (i = 0; i < 64; i++) begin
			sine_mag = $sin(i + 1.0);
			if (sine_mag < 0.0)
				sine_mag = -sine_mag;
			sine_bits = $floor(sine_mag * 4294967296.0);
			md5_sine[i] = sine_bits[31:0];
		end
		for (i = 0; i < 64; i++)
			md5_block[i] = 8'h00;
		md5_restart();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed words
		push_word(1'b0, 8'hff, 1'b0);
		push_word(1'b0, 8'h00, 1'b1);
		push_word(1'b0, 8'hff, 1'b1);
		push_word(1'b1, 8'h00, 1'b1);
		push_word(1'b1, 8'hff, 1'b0);
		push_word(1'b0, 8'h5a, 1'b0);
		push_word(1'b1, 8'h80, 1'b0);
		push_word(1'b0, 8'ha5, 1'b1);
		push_word(1'b1, 8'h61, 1'b0);
		push_word(1'b1, 8'h62, 1'b0);
		push_word(1'b1, 8'h63, 1'b1);
		push_word(1'b1, 8'h55, 1'b0);
		push_word(1'b1, 8'haa, 1'b1);
		push_word(1'b0, 8'h00, 1'b0);
		push_word(1'b0, 8'h01, 1'b1);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 57;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 57;
				end
				default: begin
					tx_idle_pct = 10;
					rx_stall_pct = 10;
				end
			endcase
			if (ph == 0) begin
				// long output hold while words keep coming
				hold_req = hold_req + 1;
				push_message(55);
				push_message(56);
				push_message(63);
				push_message(64);
				push_message(119);
				push_message(120);
			end
			phase_end = ITEM_TARGET * (ph + 1) / PHASE_COUNT;
			while (item_count < phase_end) begin
				r = $urandom_range(99);
				if (r < 65) begin
					len = $urandom_range(20);
				end else if (r < 90) begin
					case ($urandom_range(2))
						0: len = $urandom_range(57, 54);
						1: len = $urandom_range(65, 62);
						default: len = $urandom_range(121, 118);
					endcase
				end else begin
					len = $urandom_range(130);
				end
				push_message(len);
			end
			// sender waits for every digest word before the next phase
			while (word_q.size() > 0 || in_valid || digest_q.size() > 0)
				@(posedge clk);
		end

		rx_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("hashed %0d messages, %0d bytes, %0d input words", message_count,
			byte_count, item_count);
		$display("checked %0d digest words over four idling phases", result_count);
		if (err_count == 0 && digest_q.size() == 0)
			$display("md5_stream_hash_top test passed");
		else
			$display("md5_stream_hash_top test failed");
		$finish;
	end

endmodule
